// File: rtl/pointer_to_view_coordinate_mapper_core_defines.svh
// Assertion macros for the pointer-to-view mapper.
// Each macro expects clk_i and rst_ni in scope.
`ifndef POINTER_TO_VIEW_COORDINATE_MAPPER_CORE_DEFINES_SVH
`define POINTER_TO_VIEW_COORDINATE_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PVCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pvcm: property failed");
`define PVCM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pvcm: forbidden condition seen");
`else
`define PVCM_ASSERT(lbl, prop)
`define PVCM_NEVER(lbl, expr)
`endif

`endif

// File: rtl/pvcm_pkg.sv
package pvcm_pkg;

  localparam int VP_W      = 14;
  localparam int CFG_W     = 32;
  localparam int IN_W      = 20;
  localparam int OUT_W     = 40;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_CENTRE_UP = 3'd0,
    MODE_CENTRE_DN = 3'd1,
    MODE_ASPECT_UP = 3'd2,
    MODE_ASPECT_DN = 3'd3,
    MODE_BOX_LL    = 3'd4,
    MODE_BOX_UL    = 3'd5
  } pvcm_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEWPORT_W = 3'd0,
    CFG_VIEWPORT_H = 3'd1,
    CFG_UNITS      = 3'd2,
    CFG_BOX_W      = 3'd3,
    CFG_BOX_H      = 3'd4
  } pvcm_cfg_e;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Per-item flags that travel alongside the divider data
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic blank;
  } pvcm_side_t;

endpackage

// File: rtl/pointer_to_view_coordinate_mapper_core.sv
// Pipeline: start passes four front stages, one divider stage per quotient bit and one
//   clamp stage on its way to the registered result.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "pointer_to_view_coordinate_mapper_core_defines.svh"

module pointer_to_view_coordinate_mapper_core import pvcm_pkg::*; #(
  parameter int PIXEL_FRAC_BITS = 4,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic signed [IN_W-1:0]  pointer_x_i,
  input  logic signed [IN_W-1:0]  pointer_y_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] view_x_o,
  output logic signed [OUT_W-1:0] view_y_o,
  output logic                    clipped_o
);

  localparam int AW   = ((IN_W + 1 > VP_W + PIXEL_FRAC_BITS + 1) ? IN_W + 1
                        : VP_W + PIXEL_FRAC_BITS + 1) + 2;
  localparam int PW   = AW + CFG_W + 1;
  localparam int OFW  = CFG_W + VP_W + PIXEL_FRAC_BITS;
  localparam int NUMW = ((PW > OFW + 1) ? PW : OFW + 1) + 1;
  localparam int E0   = OUT_FRAC_BITS - PIXEL_FRAC_BITS - 16;
  localparam int E1   = E0 - 1;
  localparam int L0   = (E0 > 0) ? E0 : 0;
  localparam int L1   = (E1 > 0) ? E1 : 0;
  localparam int S0   = (E0 < 0) ? -E0 : 0;
  localparam int S1   = (E1 < 0) ? -E1 : 0;
  localparam int QW   = NUMW + L0 + 1;
  localparam int DSW  = VP_W + S1;
  localparam int LAT  = QW + 5;

  // Configuration registers
  logic [VP_W-1:0]  vw_q, vh_q;
  logic [CFG_W-1:0] units_q, bw_q, bh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q    <= VP_W'(640);
      vh_q    <= VP_W'(480);
      units_q <= CFG_W'(65536);
      bw_q    <= CFG_W'(65536);
      bh_q    <= CFG_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEWPORT_W: vw_q    <= cfg_data_i[VP_W-1:0];
        CFG_VIEWPORT_H: vh_q    <= cfg_data_i[VP_W-1:0];
        CFG_UNITS:      units_q <= cfg_data_i;
        CFG_BOX_W:      bw_q    <= cfg_data_i;
        CFG_BOX_H:      bh_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic           f_valid, q_valid;
  logic [QW-1:0]  dvd_x, dvd_y, quo_x, quo_y;
  logic [DSW-1:0] dsr;
  pvcm_side_t     f_side, q_side;

  pvcm_front #(
    .PFB (PIXEL_FRAC_BITS),
    .AW  (AW),
    .NUMW(NUMW),
    .L0  (L0),
    .L1  (L1),
    .S0  (S0),
    .S1  (S1),
    .DVW (QW),
    .DSW (DSW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .mode_i     (mode_i),
    .pointer_x_i(pointer_x_i),
    .pointer_y_i(pointer_y_i),
    .vw_i       (vw_q),
    .vh_i       (vh_q),
    .units_i    (units_q),
    .bw_i       (bw_q),
    .bh_i       (bh_q),
    .valid_o    (f_valid),
    .dvd_x_o    (dvd_x),
    .dvd_y_o    (dvd_y),
    .dsr_o      (dsr),
    .side_o     (f_side)
  );

  pvcm_div #(
    .QW (QW),
    .DSW(DSW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(f_valid),
    .dvd_x_i(dvd_x),
    .dvd_y_i(dvd_y),
    .dsr_i  (dsr),
    .side_i (f_side),
    .valid_o(q_valid),
    .quo_x_o(quo_x),
    .quo_y_o(quo_y),
    .side_o (q_side)
  );

  pvcm_sat #(
    .QW(QW)
  ) u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .quo_x_i  (quo_x),
    .quo_y_i  (quo_y),
    .side_i   (q_side),
    .done_o   (done_o),
    .view_x_o (view_x_o),
    .view_y_o (view_y_o),
    .clipped_o(clipped_o)
  );

  // Checks
  `PVCM_ASSERT(a_done_follows_start, done_o |-> $past(start && !busy, LAT))
  `PVCM_NEVER(a_clip_without_done, clipped_o && !done_o)
  `PVCM_ASSERT(a_clip_saturates, clipped_o |->
    (view_x_o == OUT_MAX || view_x_o == OUT_MIN || view_y_o == OUT_MAX || view_y_o == OUT_MIN))
  `PVCM_ASSERT(a_unused_mode_zero, (done_o && $past(start && (mode_i > MODE_BOX_UL), LAT)) |->
    (view_x_o == '0 && view_y_o == '0 && !clipped_o))

endmodule

// File: rtl/pvcm_front.sv
module pvcm_front import pvcm_pkg::*; #(
  parameter int PFB  = 4,
  parameter int AW   = 23,
  parameter int NUMW = 57,
  parameter int L0   = 0,
  parameter int L1   = 0,
  parameter int S0   = 4,
  parameter int S1   = 5,
  parameter int DVW  = 58,
  parameter int DSW  = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic signed [IN_W-1:0]  pointer_x_i,
  input  logic signed [IN_W-1:0]  pointer_y_i,
  input  logic [VP_W-1:0]         vw_i,
  input  logic [VP_W-1:0]         vh_i,
  input  logic [CFG_W-1:0]        units_i,
  input  logic [CFG_W-1:0]        bw_i,
  input  logic [CFG_W-1:0]        bh_i,
  output logic                    valid_o,
  output logic [DVW-1:0]          dvd_x_o,
  output logic [DVW-1:0]          dvd_y_o,
  output logic [DSW-1:0]          dsr_o,
  output pvcm_side_t              side_o
);

  localparam int PW  = AW + CFG_W + 1;
  localparam int OFW = CFG_W + VP_W;

  // ---------------- stage A: decode mode, form pixel offsets ----------------
  logic [VP_W-1:0]        wu, hu;
  logic [OFW-1:0]         cross_l, cross_r;
  logic                   wider, is_ctr, is_box, blank;
  logic signed [AW-1:0]   wf, hf, px2, py2, ax_d, ay_d;
  logic [CFG_W-1:0]       s_d, omul_d;
  logic [VP_W-1:0]        den_d, odim_d;

  always_comb begin
    wu      = (vw_i == '0) ? VP_W'(1) : vw_i;
    hu      = (vh_i == '0) ? VP_W'(1) : vh_i;
    cross_l = OFW'(wu) * OFW'(bh_i);
    cross_r = OFW'(bw_i) * OFW'(hu);
    wider   = cross_l > cross_r;
    wf      = $signed(AW'(wu) << PFB);
    hf      = $signed(AW'(hu) << PFB);
    px2     = AW'(pointer_x_i) <<< 1;
    py2     = AW'(pointer_y_i) <<< 1;
    is_ctr  = (mode_i == MODE_CENTRE_UP) || (mode_i == MODE_CENTRE_DN);
    is_box  = (mode_i == MODE_BOX_LL) || (mode_i == MODE_BOX_UL);
    blank   = mode_i > MODE_BOX_UL;
    ax_d    = (is_box && !wider) ? px2 : px2 - wf;
    case (mode_i)
      MODE_CENTRE_UP, MODE_ASPECT_UP: ay_d = hf - py2;
      MODE_CENTRE_DN, MODE_ASPECT_DN: ay_d = py2 - hf;
      MODE_BOX_LL:                    ay_d = wider ? (hf <<< 1) - py2 : hf - py2;
      MODE_BOX_UL:                    ay_d = wider ? py2 : py2 - hf;
      default:                        ay_d = '0;
    endcase
    s_d    = is_ctr ? units_i : (wider ? bh_i : bw_i);
    den_d  = (is_ctr || wider) ? hu : wu;
    omul_d = wider ? bw_i : bh_i;
    odim_d = wider ? hu : wu;
  end

  logic                 a_v_q, a_fam0_q, a_blank_q, a_offen_q, a_offx_q;
  logic signed [AW-1:0] a_ax_q, a_ay_q;
  logic [CFG_W-1:0]     a_s_q, a_omul_q;
  logic [VP_W-1:0]      a_den_q, a_odim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_fam0_q  <= is_ctr;
    a_blank_q <= blank;
    a_offen_q <= is_box;
    a_offx_q  <= wider;
    a_ax_q    <= ax_d;
    a_ay_q    <= ay_d;
    a_s_q     <= s_d;
    a_omul_q  <= omul_d;
    a_den_q   <= den_d;
    a_odim_q  <= odim_d;
  end

  // ---------------- stage B: scale products and box offset ----------------
  logic                 b_v_q, b_fam0_q, b_blank_q, b_offen_q, b_offx_q;
  logic signed [PW-1:0] b_px_q, b_py_q;
  logic [OFW-1:0]       b_off_q;
  logic [VP_W-1:0]      b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_fam0_q  <= a_fam0_q;
    b_blank_q <= a_blank_q;
    b_offen_q <= a_offen_q;
    b_offx_q  <= a_offx_q;
    b_px_q    <= PW'(a_ax_q) * $signed({1'b0, a_s_q});
    b_py_q    <= PW'(a_ay_q) * $signed({1'b0, a_s_q});
    b_off_q   <= OFW'(a_omul_q) * OFW'(a_odim_q);
    b_den_q   <= a_den_q;
  end

  // ---------------- stage C: add offset to the chosen coordinate ----------------
  logic signed [NUMW-1:0] off_s, nx_d, ny_d;

  always_comb begin
    off_s = $signed(NUMW'(b_off_q) << PFB);
    nx_d  = NUMW'(b_px_q) + ((b_offen_q && b_offx_q) ? off_s : '0);
    ny_d  = NUMW'(b_py_q) + ((b_offen_q && !b_offx_q) ? off_s : '0);
  end

  logic                   c_v_q, c_fam0_q, c_blank_q;
  logic signed [NUMW-1:0] c_nx_q, c_ny_q;
  logic [VP_W-1:0]        c_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_fam0_q  <= b_fam0_q;
    c_blank_q <= b_blank_q;
    c_nx_q    <= nx_d;
    c_ny_q    <= ny_d;
    c_den_q   <= b_den_q;
  end

  // ---------------- stage D: magnitude, scaling and rounding bias ----------------
  logic signed [DVW-1:0] nlx, nly, half;
  logic [DSW-1:0]        dsr_d;
  logic [DVW-1:0]        dvx_d, dvy_d;

  always_comb begin
    nlx   = c_fam0_q ? (DVW'(c_nx_q) <<< L0) : (DVW'(c_nx_q) <<< L1);
    nly   = c_fam0_q ? (DVW'(c_ny_q) <<< L0) : (DVW'(c_ny_q) <<< L1);
    dsr_d = c_fam0_q ? (DSW'(c_den_q) << S0) : (DSW'(c_den_q) << S1);
    half  = $signed(DVW'(dsr_d >> 1));
    // fold the absolute value into the bias add
    dvx_d = c_nx_q[NUMW-1] ? DVW'(half - nlx) : DVW'(nlx + half);
    dvy_d = c_ny_q[NUMW-1] ? DVW'(half - nly) : DVW'(nly + half);
  end

  logic d_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_x_o      <= dvx_d;
    dvd_y_o      <= dvy_d;
    dsr_o        <= dsr_d;
    side_o.neg_x <= c_nx_q[NUMW-1];
    side_o.neg_y <= c_ny_q[NUMW-1];
    side_o.blank <= c_blank_q;
  end

  assign valid_o = d_v_q;

endmodule

// File: rtl/pvcm_div.sv
module pvcm_div import pvcm_pkg::*; #(
  parameter int QW  = 58,
  parameter int DSW = 19
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [QW-1:0]  dvd_x_i,
  input  logic [QW-1:0]  dvd_y_i,
  input  logic [DSW-1:0] dsr_i,
  input  pvcm_side_t     side_i,
  output logic           valid_o,
  output logic [QW-1:0]  quo_x_o,
  output logic [QW-1:0]  quo_y_o,
  output pvcm_side_t     side_o
);

  // Stage k holds the partly shifted dividend with quotient bits entering at the bottom
  logic             v_s   [0:QW];
  logic [QW-1:0]    dqx_s [0:QW];
  logic [QW-1:0]    dqy_s [0:QW];
  logic [DSW-1:0]   rmx_s [0:QW];
  logic [DSW-1:0]   rmy_s [0:QW];
  logic [DSW-1:0]   ds_s  [0:QW];
  pvcm_side_t       sd_s  [0:QW];

  assign v_s[0]   = valid_i;
  assign dqx_s[0] = dvd_x_i;
  assign dqy_s[0] = dvd_y_i;
  assign rmx_s[0] = '0;
  assign rmy_s[0] = '0;
  assign ds_s[0]  = dsr_i;
  assign sd_s[0]  = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DSW:0]   shx, shy;
    logic           gex, gey;
    logic [DSW-1:0] rmx_d, rmy_d;
    logic           v_q;
    logic [QW-1:0]  dqx_q, dqy_q;
    logic [DSW-1:0] rmx_q, rmy_q, ds_q;
    pvcm_side_t     sd_q;

    // trial subtract of one quotient bit per coordinate
    always_comb begin
      shx   = {rmx_s[k], dqx_s[k][QW-1]};
      shy   = {rmy_s[k], dqy_s[k][QW-1]};
      gex   = shx >= {1'b0, ds_s[k]};
      gey   = shy >= {1'b0, ds_s[k]};
      rmx_d = gex ? DSW'(shx - {1'b0, ds_s[k]}) : DSW'(shx);
      rmy_d = gey ? DSW'(shy - {1'b0, ds_s[k]}) : DSW'(shy);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dqx_q <= {dqx_s[k][QW-2:0], gex};
      dqy_q <= {dqy_s[k][QW-2:0], gey};
      rmx_q <= rmx_d;
      rmy_q <= rmy_d;
      ds_q  <= ds_s[k];
      sd_q  <= sd_s[k];
    end

    assign v_s[k+1]   = v_q;
    assign dqx_s[k+1] = dqx_q;
    assign dqy_s[k+1] = dqy_q;
    assign rmx_s[k+1] = rmx_q;
    assign rmy_s[k+1] = rmy_q;
    assign ds_s[k+1]  = ds_q;
    assign sd_s[k+1]  = sd_q;
  end

  assign valid_o = v_s[QW];
  assign quo_x_o = dqx_s[QW];
  assign quo_y_o = dqy_s[QW];
  assign side_o  = sd_s[QW];

endmodule

// File: rtl/pvcm_sat.sv
module pvcm_sat import pvcm_pkg::*; #(
  parameter int QW = 58
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [QW-1:0]           quo_x_i,
  input  logic [QW-1:0]           quo_y_i,
  input  pvcm_side_t              side_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] view_x_o,
  output logic signed [OUT_W-1:0] view_y_o,
  output logic                    clipped_o
);

  // Apply sign and clamp to the output range; top bit returns the clip flag
  function automatic logic [OUT_W:0] sat_coord(logic [QW-1:0] q, logic neg);
    logic [QW-1:0]    lim;
    logic             clip;
    logic [OUT_W-1:0] val;
    lim  = QW'(OUT_MAX) + QW'(neg);
    clip = q > lim;
    if (clip) begin
      val = neg ? OUT_MIN : OUT_MAX;
    end else begin
      val = neg ? OUT_W'(-q[OUT_W-1:0]) : q[OUT_W-1:0];
    end
    return {clip, val};
  endfunction

  logic [OUT_W:0] rx, ry;

  always_comb begin
    rx = sat_coord(quo_x_i, side_i.neg_x);
    ry = sat_coord(quo_y_i, side_i.neg_y);
    if (side_i.blank) begin
      rx = '0;
      ry = '0;
    end
  end

  logic done_q, clipped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      clipped_q <= 1'b0;
    end else begin
      done_q    <= valid_i;
      clipped_q <= valid_i && (rx[OUT_W] || ry[OUT_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    view_x_o <= $signed(rx[OUT_W-1:0]);
    view_y_o <= $signed(ry[OUT_W-1:0]);
  end

  assign done_o    = done_q;
  assign clipped_o = clipped_q;

endmodule
